// ===== rtl/lrou_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lrou_pkg;

   localparam int COORD_W      = 20;
   localparam int ERR_W        = 23;
   localparam int TRIG_W       = 20;
   localparam int ANGLE_W      = 16;
   localparam int RANGE_W      = 16;
   localparam int CELL_W       = 8;
   localparam int CSR_W        = 16;
   localparam int CSR_IDX_W    = 3;
   localparam int INFL_W       = 8;
   localparam int CORDIC_ITERS = 16;
   localparam int PROD1_W      = 36;
   localparam int PROD2_W      = 52;
   localparam int QUOT_W       = 29;
   localparam int RECIP_W      = 30;
   localparam int PRODQ_W      = QUOT_W + RECIP_W;
   localparam int RECIP_SHIFT  = 39;
   localparam int DIV_SHIFT    = 24;

   localparam logic signed [16:0]     PI_Q13      = 17'sd25736;
   localparam logic signed [16:0]     HALF_PI_Q13 = 17'sd12868;
   localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 20'sd39797;
   localparam logic [PROD2_W:0]       ROUND_BIAS  = 53'd8388608000;
   // ceil(2^39 / 1000): exact quotient by 1000 for any QUOT_W-bit numerator
   localparam logic [RECIP_W-1:0]     RANGE_RECIP = 30'd549755814;

   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_PER_METER = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RANGE       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RANGE       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INFLATE         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIRROR_X        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OBSTACLE        = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FREE            = 3'd6;

   localparam logic REQ_CAST    = 1'b0;
   localparam logic REQ_READ    = 1'b1;
   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_SKIP = 1'b1;

   typedef struct packed {
      logic signed [TRIG_W-1:0] sin;
      logic signed [TRIG_W-1:0] cos;
   } trig_type;

   function automatic logic [16:0] atan_q16(input logic [3:0] idx);
      logic [16:0] v;
      case (idx)
         4'd0:  v = 17'd51472;
         4'd1:  v = 17'd30385;
         4'd2:  v = 17'd16055;
         4'd3:  v = 17'd8150;
         4'd4:  v = 17'd4091;
         4'd5:  v = 17'd2047;
         4'd6:  v = 17'd1024;
         4'd7:  v = 17'd512;
         4'd8:  v = 17'd256;
         4'd9:  v = 17'd128;
         4'd10: v = 17'd64;
         4'd11: v = 17'd32;
         4'd12: v = 17'd16;
         4'd13: v = 17'd8;
         4'd14: v = 17'd4;
         default: v = 17'd2;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/lrou_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface lrou_req_if;
   logic               valid;
   logic               ready;
   logic               req_type;
   logic signed [15:0] ray_angle;
   logic [15:0]        ray_range;
   logic               range_valid;
   logic [15:0]        cell_index;
   modport source (output valid, req_type, ray_angle, ray_range, range_valid, cell_index,
                   input ready);
   modport sink (input valid, req_type, ray_angle, ray_range, range_valid, cell_index,
                 output ready);
endinterface

interface lrou_rsp_if;
   logic              valid;
   logic              ready;
   logic              status;
   logic signed [7:0] cell_value;
   modport source (output valid, status, cell_value, input ready);
   modport sink (input valid, status, cell_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/lrou_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lrou_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 65536,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [DATA_W-1:0] wdata,
   output      logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== rtl/lrou_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lrou_cordic
   import lrou_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic signed [ANGLE_W-1:0] angle,
   output      logic                      done,
   output      trig_type                  trig
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [3:0]               iter_ff, iter_in;
   logic                     neg_ff, neg_in;
   logic signed [TRIG_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [16:0]       a_ext, a_red;
   logic signed [TRIG_W-1:0] xs, ys, at;

   always_comb begin
      a_ext = 17'(angle);
      a_red = a_ext;
      neg_in = neg_ff;
      if (a_ext > HALF_PI_Q13) begin
         a_red = a_ext - PI_Q13;
      end else if (a_ext < -HALF_PI_Q13) begin
         a_red = a_ext + PI_Q13;
      end
      xs = x_ff >>> iter_ff;
      ys = y_ff >>> iter_ff;
      at = TRIG_W'(atan_q16(iter_ff));
      busy_in = busy_ff;
      done_in = 1'b0;
      iter_in = iter_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      if (start) begin
         busy_in = 1'b1;
         iter_in = '0;
         neg_in = (a_ext > HALF_PI_Q13) || (a_ext < -HALF_PI_Q13);
         x_in = CORDIC_GAIN;
         y_in = '0;
         z_in = {a_red, 3'b000};
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         iter_in = iter_ff + 4'd1;
         if (iter_ff == 4'(CORDIC_ITERS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
      neg_ff <= neg_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
   end

   assign done = done_ff;
   assign trig.sin = neg_ff ? -y_ff : y_ff;
   assign trig.cos = neg_ff ? -x_ff : x_ff;

endmodule
`default_nettype wire

// ===== rtl/lrou_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lrou_scale
   import lrou_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic signed [TRIG_W-1:0]   trig_val,
   input  wire logic [RANGE_W-1:0]         range_mm,
   input  wire logic [CSR_W-1:0]           cells_per_meter,
   output      logic                       done,
   output      logic signed [COORD_W-1:0]  cells
);

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_MUL1  = 3'd1;
   localparam logic [2:0] PH_MUL2  = 3'd2;
   localparam logic [2:0] PH_ROUND = 3'd3;
   localparam logic [2:0] PH_DIV   = 3'd4;

   logic [2:0]          phase_ff, phase_in;
   logic                done_ff, done_in;
   logic                neg_ff, neg_in;
   logic [TRIG_W-1:0]   mag_ff, mag_in;
   logic [PROD1_W-1:0]  p1_ff, p1_in;
   logic [PROD2_W-1:0]  p2_ff, p2_in;
   logic [QUOT_W-1:0]   num_ff, num_in;
   logic [PRODQ_W-1:0]  quot_ff, quot_in;
   logic [PROD2_W:0]    biased;

   always_comb begin
      phase_in = phase_ff;
      done_in = 1'b0;
      neg_in = neg_ff;
      mag_in = mag_ff;
      p1_in = p1_ff;
      p2_in = p2_ff;
      num_in = num_ff;
      quot_in = quot_ff;
      biased = {1'b0, p2_ff} + ROUND_BIAS;
      case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               neg_in = trig_val < 0;
               mag_in = (trig_val < 0) ? TRIG_W'(-trig_val) : TRIG_W'(trig_val);
               phase_in = PH_MUL1;
            end
         end
         PH_MUL1: begin
            p1_in = PROD1_W'(mag_ff) * PROD1_W'(range_mm);
            phase_in = PH_MUL2;
         end
         PH_MUL2: begin
            p2_in = PROD2_W'(p1_ff) * PROD2_W'(cells_per_meter);
            phase_in = PH_ROUND;
         end
         PH_ROUND: begin
            num_in = biased[DIV_SHIFT +: QUOT_W];
            phase_in = PH_DIV;
         end
         PH_DIV: begin
            quot_in = PRODQ_W'(num_ff) * PRODQ_W'(RANGE_RECIP);
            phase_in = PH_IDLE;
            done_in = 1'b1;
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff <= done_in;
      end
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
      num_ff  <= num_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign cells = neg_ff ? -$signed(quot_ff[RECIP_SHIFT +: COORD_W])
                         : $signed(quot_ff[RECIP_SHIFT +: COORD_W]);

endmodule
`default_nettype wire

// ===== rtl/lidar_ray_occupancy_update_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Read item: the cell is read from the map RAM and then written to zero.
// Cast ray: the CORDIC and the two scale passes, then one RAM read per line cell,
// written only if below the obstacle value, and up to 4*k*k inflation writes.
// One item in flight; the single map RAM port sets the pace of the walk.
// Reset: config returns to defaults and a clearing pass writes zero to every cell
// before the first request transfer.
module lidar_ray_occupancy_update_top
   import lrou_pkg::*;
#(
   parameter int MAP_WIDTH   = 256,
   parameter int MAP_HEIGHT  = 256,
   parameter int MAX_INFLATE = 15
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata,
   lrou_req_if.sink                  req_ch,
   lrou_rsp_if.source                rsp_ch
);

   localparam int MAP_CELLS = MAP_WIDTH * MAP_HEIGHT;
   localparam int ADDR_W    = $clog2(MAP_CELLS);
   localparam int HALF_W    = MAP_WIDTH / 2;

   localparam logic [3:0] ST_CLEAR     = 4'd0;
   localparam logic [3:0] ST_IDLE      = 4'd1;
   localparam logic [3:0] ST_CHECK     = 4'd2;
   localparam logic [3:0] ST_READ      = 4'd3;
   localparam logic [3:0] ST_READ_DATA = 4'd4;
   localparam logic [3:0] ST_CORDIC    = 4'd5;
   localparam logic [3:0] ST_SCALE_X   = 4'd6;
   localparam logic [3:0] ST_SCALE_Y   = 4'd7;
   localparam logic [3:0] ST_END_PUT   = 4'd8;
   localparam logic [3:0] ST_W_RD      = 4'd9;
   localparam logic [3:0] ST_W_WR      = 4'd10;
   localparam logic [3:0] ST_W_STEP    = 4'd11;
   localparam logic [3:0] ST_INFL      = 4'd12;
   localparam logic [3:0] ST_DONE      = 4'd13;

   function automatic logic in_map(input logic signed [COORD_W-1:0] cx,
                                   input logic signed [COORD_W-1:0] cy);
      int ax;
      ax = (cx < 0) ? -int'(cx) : int'(cx);
      return (ax < HALF_W) && (int'(cy) < MAP_HEIGHT) && (cy > 0);
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic signed [COORD_W-1:0] cx,
                                                   input logic signed [COORD_W-1:0] cy);
      int lin;
      lin = HALF_W - int'(cx) + int'(cy) * MAP_WIDTH;
      return ADDR_W'(lin);
   endfunction

   logic [CSR_W-1:0]         cpm_ff, minr_ff, maxr_ff;
   logic [3:0]               infl_ff;
   logic                     mirror_ff;
   logic signed [CELL_W-1:0] obst_ff, free_ff;

   logic [3:0]                state_ff, state_in;
   logic [ADDR_W-1:0]         clr_ff, clr_in;
   logic                      type_ff, rvalid_ff, rd_ok_ff;
   logic signed [ANGLE_W-1:0] angle_ff;
   logic [RANGE_W-1:0]        range_ff;
   logic [ADDR_W-1:0]         rd_addr_ff;
   logic                      res_status_ff, res_status_in;
   logic signed [CELL_W-1:0]  res_cell_ff, res_cell_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_status_ff, rsp_status_in;
   logic signed [CELL_W-1:0]  rsp_cell_ff, rsp_cell_in;

   logic signed [COORD_W-1:0] x_ff, x_in, y_ff, y_in, x1_ff, x1_in, y1_ff, y1_in;
   logic signed [COORD_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic                      sxp_ff, sxp_in, syp_ff, syp_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [INFL_W-1:0]  i_ff, i_in, j_ff, j_in;

   logic                      req_take;
   logic [6:0]                k_eff;
   logic signed [INFL_W-1:0]  neg_k, k_m1;
   logic signed [ERR_W:0]     e2;
   logic                      stepx, stepy;
   logic signed [ERR_W-1:0]   err_a;
   logic signed [COORD_W-1:0] x_a, cx, cy;

   logic                      mem_we;
   logic [ADDR_W-1:0]         mem_addr;
   logic [CELL_W-1:0]         mem_wdata, mem_rdata;

   logic                      cordic_start, cordic_done, scale_start, scale_done;
   trig_type                  trig;
   logic signed [TRIG_W-1:0]  scale_trig;
   logic signed [COORD_W-1:0] scale_cells;

   lrou_ram #(.DATA_W(CELL_W), .DEPTH(MAP_CELLS)) u_map (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   lrou_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .angle (angle_ff),
      .done  (cordic_done),
      .trig  (trig)
   );

   lrou_scale u_scale (
      .clock           (clock),
      .reset           (reset),
      .start           (scale_start),
      .trig_val        (scale_trig),
      .range_mm        (range_ff),
      .cells_per_meter (cpm_ff),
      .done            (scale_done),
      .cells           (scale_cells)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take = req_ch.valid && (state_ff == ST_IDLE);

   assign k_eff = (int'(infl_ff) > MAX_INFLATE) ? 7'(MAX_INFLATE) : 7'(infl_ff);
   assign neg_k = -$signed({1'b0, k_eff});
   assign k_m1  = $signed({1'b0, k_eff}) - INFL_W'(1);
   assign cx = x1_ff + COORD_W'(i_ff);
   assign cy = y1_ff + COORD_W'(j_ff);
   assign scale_trig = (state_ff == ST_CORDIC) ? trig.sin : trig.cos;

   assign e2    = (ERR_W+1)'(err_ff) <<< 1;
   assign stepx = e2 > -((ERR_W+1)'(dy_ff));
   assign stepy = e2 < (ERR_W+1)'(dx_ff);
   assign err_a = stepx ? err_ff - ERR_W'(dy_ff) : err_ff;
   assign x_a   = stepx ? (sxp_ff ? x_ff + COORD_W'(1) : x_ff - COORD_W'(1)) : x_ff;

   always_comb begin
      mem_we = 1'b0;
      mem_addr = cell_addr(x_ff, y_ff);
      mem_wdata = '0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_addr = clr_ff;
         end
         ST_READ: mem_addr = rd_addr_ff;
         ST_READ_DATA: begin
            mem_we = 1'b1;
            mem_addr = rd_addr_ff;
         end
         ST_END_PUT: begin
            mem_we = in_map(x1_ff, y1_ff);
            mem_addr = cell_addr(x1_ff, y1_ff);
            mem_wdata = obst_ff;
         end
         ST_W_WR: begin
            mem_we = $signed(mem_rdata) < obst_ff;
            mem_wdata = free_ff;
         end
         ST_INFL: begin
            mem_we = in_map(cx, cy);
            mem_addr = cell_addr(cx, cy);
            mem_wdata = obst_ff;
         end
         default: mem_we = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      res_status_in = res_status_ff;
      res_cell_in = res_cell_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_cell_in = rsp_cell_ff;
      x_in = x_ff;
      y_in = y_ff;
      x1_in = x1_ff;
      y1_in = y1_ff;
      dx_in = dx_ff;
      dy_in = dy_ff;
      sxp_in = sxp_ff;
      syp_in = syp_ff;
      err_in = err_ff;
      i_in = i_ff;
      j_in = j_ff;
      cordic_start = 1'b0;
      scale_start = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(MAP_CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            res_status_in = STATUS_DONE;
            res_cell_in = '0;
            if (type_ff == REQ_READ) begin
               state_in = rd_ok_ff ? ST_READ : ST_DONE;
            end else if (!rvalid_ff || range_ff < minr_ff || range_ff > maxr_ff) begin
               res_status_in = STATUS_SKIP;
               state_in = ST_DONE;
            end else begin
               cordic_start = 1'b1;
               state_in = ST_CORDIC;
            end
         end
         ST_READ: state_in = ST_READ_DATA;
         ST_READ_DATA: begin
            res_cell_in = $signed(mem_rdata);
            state_in = ST_DONE;
         end
         ST_CORDIC: begin
            if (cordic_done) begin
               scale_start = 1'b1;
               state_in = ST_SCALE_X;
            end
         end
         ST_SCALE_X: begin
            if (scale_done) begin
               x1_in = mirror_ff ? -scale_cells : scale_cells;
               scale_start = 1'b1;
               state_in = ST_SCALE_Y;
            end
         end
         ST_SCALE_Y: begin
            if (scale_done) begin
               y1_in = scale_cells;
               state_in = ST_END_PUT;
            end
         end
         ST_END_PUT: begin
            dx_in = (x1_ff < 0) ? -x1_ff : x1_ff;
            dy_in = (y1_ff < 0) ? -y1_ff : y1_ff;
            err_in = ERR_W'((x1_ff < 0) ? -x1_ff : x1_ff)
                   - ERR_W'((y1_ff < 0) ? -y1_ff : y1_ff);
            sxp_in = x1_ff > 0;
            syp_in = y1_ff > 0;
            x_in = '0;
            y_in = '0;
            state_in = ST_W_RD;
         end
         ST_W_RD: state_in = in_map(x_ff, y_ff) ? ST_W_WR : ST_W_STEP;
         ST_W_WR: state_in = ST_W_STEP;
         ST_W_STEP: begin
            i_in = neg_k;
            j_in = neg_k;
            if (x_ff == x1_ff && y_ff == y1_ff) begin
               state_in = (k_eff == '0) ? ST_DONE : ST_INFL;
            end else begin
               x_in = x_a;
               err_in = err_a;
               if (x_a == x1_ff && y_ff == y1_ff) begin
                  state_in = (k_eff == '0) ? ST_DONE : ST_INFL;
               end else begin
                  if (stepy) begin
                     err_in = err_a + ERR_W'(dx_ff);
                     y_in = syp_ff ? y_ff + COORD_W'(1) : y_ff - COORD_W'(1);
                  end
                  state_in = ST_W_RD;
               end
            end
         end
         ST_INFL: begin
            if (j_ff == k_m1) begin
               j_in = neg_k;
               i_in = i_ff + INFL_W'(1);
               if (i_ff == k_m1) begin
                  state_in = ST_DONE;
               end
            end else begin
               j_in = j_ff + INFL_W'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_cell_in = res_cell_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         cpm_ff <= 16'd256;
         minr_ff <= 16'd200;
         maxr_ff <= 16'd8000;
         infl_ff <= 4'd8;
         mirror_ff <= 1'b1;
         obst_ff <= 8'sd100;
         free_ff <= 8'sd0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_CELLS_PER_METER: cpm_ff <= csr_wdata;
               CSR_MIN_RANGE:       minr_ff <= csr_wdata;
               CSR_MAX_RANGE:       maxr_ff <= csr_wdata;
               CSR_INFLATE:         infl_ff <= csr_wdata[3:0];
               CSR_MIRROR_X:        mirror_ff <= csr_wdata[0];
               CSR_OBSTACLE:        obst_ff <= $signed(csr_wdata[CELL_W-1:0]);
               CSR_FREE:            free_ff <= $signed(csr_wdata[CELL_W-1:0]);
               default:             cpm_ff <= cpm_ff;
            endcase
         end
      end
      if (req_take) begin
         type_ff <= req_ch.req_type;
         angle_ff <= req_ch.ray_angle;
         range_ff <= req_ch.ray_range;
         rvalid_ff <= req_ch.range_valid;
         rd_ok_ff <= {16'd0, req_ch.cell_index} < 32'(MAP_CELLS);
         rd_addr_ff <= ADDR_W'(req_ch.cell_index);
      end
      res_status_ff <= res_status_in;
      res_cell_ff <= res_cell_in;
      rsp_status_ff <= rsp_status_in;
      rsp_cell_ff <= rsp_cell_in;
      x_ff <= x_in;
      y_ff <= y_in;
      x1_ff <= x1_in;
      y1_ff <= y1_in;
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      sxp_ff <= sxp_in;
      syp_ff <= syp_in;
      err_ff <= err_in;
      i_ff <= i_in;
      j_ff <= j_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.cell_value = rsp_cell_ff;

endmodule
`default_nettype wire
